[rtl/core/owned_slot_allocator_assert.svh]
// Assertion macros for the owned slot allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef OWNED_SLOT_ALLOCATOR_ASSERT_SVH
`define OWNED_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define OSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owned_slot_allocator: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define OSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owned_slot_allocator: next-cycle check failed");

`endif

[rtl/core/osa_pkg.sv]
// Shared types and constants of the owned slot allocator.
// No dependencies; used by osa_dp, osa_ctrl and owned_slot_allocator.
`default_nettype none

package osa_pkg;

    // default sizes
    localparam int DEF_TABLES  = 4;
    localparam int DEF_SEATS   = 16;
    localparam int DEF_ID_BITS = 32;

    // beat field widths
    localparam int OP_W     = 2;
    localparam int TAB_W    = 2;
    localparam int SLOT_W   = 8;
    localparam int OWNER_W  = 32;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 4;

    // input tdata layout, low bit up
    localparam int IN_OP_LSB    = 0;
    localparam int IN_TAB_LSB   = IN_OP_LSB + OP_W;
    localparam int IN_SLOT_LSB  = IN_TAB_LSB + TAB_W;
    localparam int IN_OWNER_LSB = IN_SLOT_LSB + SLOT_W;
    localparam int IN_BITS      = IN_OWNER_LSB + OWNER_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout, low bit up
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_GRANT_LSB  = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_OWNER_LSB  = OUT_GRANT_LSB + GRANT_W;
    localparam int OUT_BITS       = OUT_OWNER_LSB + OWNER_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // opcodes
    localparam logic [OP_W-1:0] OP_CLAIM   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SEATED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd5;

    // how the datapath closes out an item
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_BAD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLAIM   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic              load;       // latch request, fetch free word
        logic              scan_init;  // reset scan, read entry 0
        logic              scan_step;  // compare entry, read next
        logic              rd_slot;    // read addressed entry
        logic              commit;     // update state, load result
        logic [KIND_W-1:0] kind;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic            bad;
        logic [OP_W-1:0] op;
        logic            full;
        logic            scan_last;
        logic            out_busy;
    } t_sts;

endpackage

`default_nettype wire

[rtl/core/osa_dp.sv]
// Datapath of the owned slot allocator: request registers, free bitmaps,
// owner memory, duplicate scan and result register. Uses osa_pkg.
`default_nettype none
`include "owned_slot_allocator_assert.svh"

module osa_dp #(
    parameter int TABLES  = osa_pkg::DEF_TABLES,
    parameter int SEATS   = osa_pkg::DEF_SEATS,
    parameter int ID_BITS = osa_pkg::DEF_ID_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  osa_pkg::t_cmd                      i_cmd,
    output osa_pkg::t_sts                      o_sts,
    input  wire  [osa_pkg::OP_W-1:0]           i_opcode,
    input  wire  [osa_pkg::TAB_W-1:0]          i_table_index,
    input  wire  [osa_pkg::SLOT_W-1:0]         i_slot_index,
    input  wire  [osa_pkg::OWNER_W-1:0]        i_owner_id,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic [osa_pkg::STATUS_W-1:0]       o_status,
    output logic [osa_pkg::GRANT_W-1:0]        o_granted_slot,
    output logic [osa_pkg::OWNER_W-1:0]        o_slot_owner
);

    localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int SW    = (SEATS > 1) ? $clog2(SEATS) : 1;
    localparam int DEPTH = TABLES * SEATS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // request
    logic [osa_pkg::OP_W-1:0]   r_op;
    logic [osa_pkg::TAB_W-1:0]  r_tab;
    logic [osa_pkg::SLOT_W-1:0] r_slot;
    logic [ID_BITS-1:0]         r_id;
    logic [SEATS-1:0]           r_fb;

    // state
    logic [SEATS-1:0]   r_free [TABLES];
    logic [ID_BITS-1:0] r_mem  [DEPTH];
    logic [ID_BITS-1:0] r_rd_data;

    // scan
    logic [SW-1:0] r_cnt;
    logic [SW-1:0] r_first;
    logic          r_dup;
    logic          r_found;

    // result
    logic                         r_out_valid;
    logic [osa_pkg::STATUS_W-1:0] r_out_status;
    logic [osa_pkg::GRANT_W-1:0]  r_out_granted;
    logic [osa_pkg::OWNER_W-1:0]  r_out_owner;

    logic [TW-1:0]                t_idx;
    logic [SW-1:0]                s_idx;
    logic [AW-1:0]                base;
    logic                         slot_free;
    logic                         scan_last;
    logic                         rd_en;
    logic [SW-1:0]                rd_idx;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic                         wr_en;
    logic                         free_clr;
    logic                         free_set;
    logic [SW-1:0]                n_grant;
    logic [osa_pkg::STATUS_W-1:0] n_out_status;
    logic [osa_pkg::GRANT_W-1:0]  n_out_granted;
    logic [ID_BITS-1:0]           n_owner;
    logic                         claim_commit;

    assign t_idx     = TW'(r_tab);
    assign s_idx     = SW'(r_slot);
    assign base      = AW'(AW'(t_idx) * AW'(SEATS));
    assign slot_free = r_fb[s_idx];
    assign scan_last = (r_cnt == SW'(SEATS - 1));

    assign o_sts.bad       = (r_op == osa_pkg::OP_UNUSED) || (32'(r_tab) >= 32'(TABLES))
                             || (32'(r_slot) >= 32'(SEATS));
    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_fb == '0);
    assign o_sts.scan_last = scan_last;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    // request capture; free word of the addressed table is copied here
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_tab  <= i_table_index;
            r_slot <= i_slot_index;
            r_id   <= ID_BITS'(i_owner_id);
            r_fb   <= r_free[TW'(i_table_index)];
        end
    end

    // owner memory, one read and one write port
    always_comb begin
        rd_idx = '0;
        if (i_cmd.scan_step) begin
            rd_idx = SW'(r_cnt + SW'(1));
        end else if (i_cmd.rd_slot) begin
            rd_idx = s_idx;
        end
    end

    assign rd_en   = i_cmd.scan_init || (i_cmd.scan_step && !scan_last) || i_cmd.rd_slot;
    assign rd_addr = AW'(base + AW'(rd_idx));
    assign wr_addr = AW'(base + AW'(n_grant));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_id;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // duplicate scan; r_rd_data holds entry r_cnt during a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup   <= 1'b0;
            r_found <= 1'b0;
            r_first <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.scan_init) begin
            r_dup   <= 1'b0;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else if (i_cmd.scan_step) begin
            if (!r_fb[r_cnt] && (r_rd_data == r_id)) begin
                r_dup <= 1'b1;
            end
            if (r_fb[r_cnt] && !r_found) begin
                r_found <= 1'b1;
                r_first <= r_cnt;
            end
            if (!scan_last) begin
                r_cnt <= SW'(r_cnt + SW'(1));
            end
        end
    end

    // close-out decision
    always_comb begin
        n_out_status  = osa_pkg::ST_OK;
        n_grant       = s_idx;
        n_owner       = '0;
        wr_en         = 1'b0;
        free_clr      = 1'b0;
        free_set      = 1'b0;
        case (i_cmd.kind)
            osa_pkg::KIND_BAD: begin
                n_out_status = osa_pkg::ST_BAD_INDEX;
            end
            osa_pkg::KIND_FULL: begin
                n_out_status = osa_pkg::ST_FULL;
            end
            osa_pkg::KIND_CLAIM: begin
                if (r_dup) begin
                    n_out_status = osa_pkg::ST_SEATED;
                end else begin
                    n_grant  = slot_free ? s_idx : r_first;
                    wr_en    = i_cmd.commit;
                    free_clr = i_cmd.commit;
                end
            end
            osa_pkg::KIND_RELEASE: begin
                if (slot_free) begin
                    n_out_status = osa_pkg::ST_EMPTY;
                end else if (r_rd_data != r_id) begin
                    n_out_status = osa_pkg::ST_MISMATCH;
                end else begin
                    // memory entry of a free slot is never used, so no zero write
                    free_set = i_cmd.commit;
                end
            end
            osa_pkg::KIND_QUERY: begin
                n_owner = slot_free ? '0 : r_rd_data;
            end
            default: begin
                n_out_status = osa_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    always_comb begin
        n_out_granted = r_slot[osa_pkg::GRANT_W-1:0];
        if ((i_cmd.kind == osa_pkg::KIND_CLAIM) && !r_dup) begin
            n_out_granted = osa_pkg::GRANT_W'(n_grant);
        end
    end

    // free bitmaps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TABLES; t++) begin
                r_free[t] <= '1;
            end
        end else if (free_clr) begin
            r_free[t_idx][n_grant] <= 1'b0;
        end else if (free_set) begin
            r_free[t_idx][s_idx] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.commit || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status  <= n_out_status;
            r_out_granted <= n_out_granted;
            r_out_owner   <= osa_pkg::OWNER_W'(n_owner);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_granted;
    assign o_slot_owner   = r_out_owner;

    assign claim_commit = i_cmd.commit && (i_cmd.kind == osa_pkg::KIND_CLAIM) && !r_dup;

    `OSA_ASSERT_NEXT(a_commit_loads_result, i_clk, i_rst_n, i_cmd.commit, r_out_valid)
    `OSA_ASSERT_NOW(a_first_free_is_free, i_clk, i_rst_n, i_cmd.scan_step && r_found, r_fb[r_first])
    `OSA_ASSERT_NOW(a_claim_takes_free_slot, i_clk, i_rst_n, claim_commit, r_fb[n_grant])

endmodule

`default_nettype wire

[rtl/core/osa_ctrl.sv]
// Controller of the owned slot allocator: sequences check, scan and close-out.
// Uses osa_pkg command and status types; drives osa_dp.
`default_nettype none

module osa_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  osa_pkg::t_sts i_sts,
    output osa_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic [osa_pkg::KIND_W-1:0]   r_kind;
    logic [osa_pkg::KIND_W-1:0]   n_kind;

    // no beat is taken while reset is held
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_kind          = r_kind;
        o_cmd           = '0;
        o_cmd.kind      = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                if (i_sts.bad) begin
                    n_kind = osa_pkg::KIND_BAD;
                end else if (i_sts.op == osa_pkg::OP_CLAIM) begin
                    if (i_sts.full) begin
                        n_kind = osa_pkg::KIND_FULL;
                    end else begin
                        n_kind          = osa_pkg::KIND_CLAIM;
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end else if (i_sts.op == osa_pkg::OP_RELEASE) begin
                    n_kind        = osa_pkg::KIND_RELEASE;
                    o_cmd.rd_slot = 1'b1;
                end else begin
                    n_kind        = osa_pkg::KIND_QUERY;
                    o_cmd.rd_slot = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= osa_pkg::KIND_BAD;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

[rtl/core/owned_slot_allocator.sv]
// Top level of the owned slot allocator: stream ports, controller and datapath.
// Depends on osa_pkg, osa_ctrl and osa_dp.
//
//  channel | dir | handshake                 | tdata fields (low bit up)
//  --------+-----+---------------------------+---------------------------------------
//  request | in  | i_s_tvalid / o_s_tready   | opcode 2, table_index 2, slot_index 8,
//          |     |                           | owner_id 32, 4 pad bits
//  result  | out | o_m_tvalid / i_m_tready   | status 3, granted_slot 4, slot_owner 32,
//          |     |                           | 1 pad bit
//
// One request at a time. A claim that passes the early checks scans all SEATS
// owner entries of its table through the single read port of the owner memory,
// one entry a cycle, between the check and the close-out.
// Release, query, bad-index and full-table requests skip the scan and go from the check to close-out.
// The result register decouples the sides: a new request is taken while the
// last result waits; close-out stalls only if that result is still pending.
// Reset (synchronous, active low) marks every slot free at once; owner memory
// has no reset and needs no clearing pass, since a free slot's entry is never
// used and a query of a free slot answers owner 0.
`default_nettype none

module owned_slot_allocator #(
    parameter int TABLES  = osa_pkg::DEF_TABLES,
    parameter int SEATS   = osa_pkg::DEF_SEATS,
    parameter int ID_BITS = osa_pkg::DEF_ID_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // request beat
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // opcode[1:0], table_index[3:2], slot_index[11:4], owner_id[43:12], zero[47:44]
    input  wire  [osa_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // result beat
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // status[2:0], granted_slot[6:3], slot_owner[38:7], zero[39]
    output logic [osa_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    osa_pkg::t_cmd cmd;
    osa_pkg::t_sts sts;

    logic [osa_pkg::STATUS_W-1:0] out_status;
    logic [osa_pkg::GRANT_W-1:0]  out_granted;
    logic [osa_pkg::OWNER_W-1:0]  out_owner;

    osa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    osa_dp #(
        .TABLES  (TABLES),
        .SEATS   (SEATS),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_s_tdata[osa_pkg::IN_OP_LSB +: osa_pkg::OP_W]),
        .i_table_index  (i_s_tdata[osa_pkg::IN_TAB_LSB +: osa_pkg::TAB_W]),
        .i_slot_index   (i_s_tdata[osa_pkg::IN_SLOT_LSB +: osa_pkg::SLOT_W]),
        .i_owner_id     (i_s_tdata[osa_pkg::IN_OWNER_LSB +: osa_pkg::OWNER_W]),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_status       (out_status),
        .o_granted_slot (out_granted),
        .o_slot_owner   (out_owner)
    );

    // pack result beat, pad bits zero
    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[osa_pkg::OUT_STATUS_LSB +: osa_pkg::STATUS_W] = out_status;
        o_m_tdata[osa_pkg::OUT_GRANT_LSB +: osa_pkg::GRANT_W]   = out_granted;
        o_m_tdata[osa_pkg::OUT_OWNER_LSB +: osa_pkg::OWNER_W]   = out_owner;
    end

endmodule

`default_nettype wire
